FILE: design/assert_macros.svh
// Assertion macros shared by the RTL; clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/hbbct_pkg.sv
// Package for the block cache tag store: sizes, codes, state and command types.
package hbbct_pkg;

	localparam int NUM_ENTRIES = 30;
	localparam int NUM_BUCKETS = 13;

	localparam int OP_W    = 2;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int IDX_W   = 5;
	localparam int TICK_W  = 31;
	localparam int SLOT_W  = 5;
	localparam int FAULT_W = 2;
	localparam int REF_W   = 8;

	localparam int ENT_W  = $clog2(NUM_ENTRIES);
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	// bucket residue in three steps: byte sum weighted by 2^(8j) mod NUM_BUCKETS,
	// quotient by reciprocal multiplication, remainder
	localparam int DIG_STEPS = 3;
	localparam int DIG_CNT_W = $clog2(DIG_STEPS);
	localparam int RES_W     = 16;
	localparam int RECIP_SH  = RES_W + 6;
	localparam int MUL_W     = RES_W + RECIP_SH + 1;
	localparam longint RECIP_M = ((longint'(1) << RECIP_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;
	localparam int BYTE_WT0  = 1 % NUM_BUCKETS;
	localparam int BYTE_WT1  = (1 << 8) % NUM_BUCKETS;
	localparam int BYTE_WT2  = (1 << 16) % NUM_BUCKETS;
	localparam int BYTE_WT3  = (1 << 24) % NUM_BUCKETS;

	localparam int BKT_BASE     = NUM_ENTRIES / NUM_BUCKETS;
	localparam int BKT_EXTRA    = NUM_ENTRIES % NUM_BUCKETS;
	localparam int BKT_BIG      = BKT_BASE + 1;
	localparam int BKT_BASE_DIV = (BKT_BASE == 0) ? 1 : BKT_BASE;
	localparam int BKT_SPLIT    = BKT_EXTRA * BKT_BIG;

	localparam logic [REF_W-1:0] REF_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	localparam logic [FAULT_W-1:0] FAULT_OK     = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_NOFREE = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_REFCNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUCKET,
		ST_SCAN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic dig_step;
		logic scan_step;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic dig_last;
		logic scan_last;
		logic out_free;
	} dp_status_t;

	// reset bucket of an entry: buckets dealt in index order, the first ones one larger
	function automatic logic [BKT_W-1:0] init_bucket(input int e);
		int b;
		if (e < BKT_SPLIT)
			b = e / BKT_BIG;
		else
			b = BKT_EXTRA + (e - BKT_SPLIT) / BKT_BASE_DIV;
		return BKT_W'(b);
	endfunction

endpackage

FILE: design/hashed_bucket_block_cache_tags.sv
// Top level of the block cache tag store.
// Get: the accepted beat goes through the bucket residue, the tag scan (one entry a cycle)
// and the update; no new beat is taken until the get has written its result.
// Release, pin, unpin: no residue or scan, straight to the update; one beat at a time.
// A new beat is taken while the previous result waits in the output register.
// Asynchronous reset loads the tag store with its initial bucket spread at once.
`include "assert_macros.svh"

module hashed_bucket_block_cache_tags (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [hbbct_pkg::OP_W-1:0]       operation,
	input  logic [hbbct_pkg::DEV_W-1:0]      device,
	input  logic [hbbct_pkg::BLK_W-1:0]      block_number,
	input  logic [hbbct_pkg::IDX_W-1:0]      entry_index,
	input  logic [hbbct_pkg::TICK_W-1:0]     now_ticks,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [hbbct_pkg::SLOT_W-1:0]     slot,
	output logic                             was_hit,
	output logic                             needs_read,
	output logic [hbbct_pkg::FAULT_W-1:0]    fault
);
	import hbbct_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	hbbct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op_t'(operation)),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	hbbct_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (operation),
		.device       (device),
		.block_number (block_number),
		.entry_index  (entry_index),
		.now_ticks    (now_ticks),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.slot         (slot),
		.was_hit      (was_hit),
		.needs_read   (needs_read),
		.fault        (fault)
	);

	`ASSERT_IMPL(a_nofree_clean, out_valid && fault == FAULT_NOFREE, slot == '0 && !was_hit && !needs_read, "no-free result not clean")
	`ASSERT_IMPL(a_read_ok, out_valid && needs_read, fault == FAULT_OK, "read request on faulted beat")
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")

endmodule

FILE: design/hbbct_ctrl.sv
// Controller state machine for the block cache tag store.
module hbbct_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  hbbct_pkg::op_t         op,
	input  hbbct_pkg::dp_status_t  status,
	output logic                   in_stall,
	output hbbct_pkg::dp_cmd_t     cmd
);
	import hbbct_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_GET) ? ST_BUCKET : ST_EXEC;
				end
			end
			ST_BUCKET: begin
				if (status.dig_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.out_free) state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.dig_step  = (state_q == ST_BUCKET);
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.exec      = (state_q == ST_EXEC) && status.out_free;
	end

endmodule

FILE: design/hbbct_dp.sv
// Datapath: tag store, bucket residue, entry scan, update and result register.
module hbbct_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hbbct_pkg::dp_cmd_t               cmd,
	output hbbct_pkg::dp_status_t            status,
	input  logic [hbbct_pkg::OP_W-1:0]       operation,
	input  logic [hbbct_pkg::DEV_W-1:0]      device,
	input  logic [hbbct_pkg::BLK_W-1:0]      block_number,
	input  logic [hbbct_pkg::IDX_W-1:0]      entry_index,
	input  logic [hbbct_pkg::TICK_W-1:0]     now_ticks,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic [hbbct_pkg::SLOT_W-1:0]     slot,
	output logic                             was_hit,
	output logic                             needs_read,
	output logic [hbbct_pkg::FAULT_W-1:0]    fault
);
	import hbbct_pkg::*;

	// tag store
	logic [DEV_W-1:0]       tag_dev_q [NUM_ENTRIES];
	logic [BLK_W-1:0]       tag_blk_q [NUM_ENTRIES];
	logic [BKT_W-1:0]       tag_bkt_q [NUM_ENTRIES];
	logic [REF_W-1:0]       ref_q     [NUM_ENTRIES];
	logic [TICK_W-1:0]      rtime_q   [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] cv_q;

	// request
	op_t               op_q;
	logic [DEV_W-1:0]  dev_q;
	logic [BLK_W-1:0]  blk_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TICK_W-1:0] now_q;

	// sequencing and scan candidates
	logic [DIG_CNT_W-1:0] dig_q;
	logic [RES_W-1:0]     sum_q;
	logic [RES_W-1:0]     quo_q;
	logic [BKT_W-1:0]     rem_q;
	logic [ENT_W-1:0]     scan_q;
	logic                 hit_found_q;
	logic [ENT_W-1:0]     hit_idx_q;
	logic                 bf_found_q;
	logic [ENT_W-1:0]     bf_idx_q;
	logic [TICK_W-1:0]    bf_time_q;
	logic                 gf_found_q;
	logic [ENT_W-1:0]     gf_idx_q;
	logic [TICK_W-1:0]    gf_time_q;

	// result register
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 hit_q;
	logic                 rd_q;
	logic [FAULT_W-1:0]   fault_q;

	logic [RES_W-1:0]  sum_n;
	logic [MUL_W-1:0]  prod;
	logic [RES_W-1:0]  rem_full;
	logic [BKT_W-1:0]  rem_n;
	logic              idx_ok;
	logic [ENT_W-1:0]  tgt_idx;
	logic [ENT_W-1:0]  rd_addr;
	logic [DEV_W-1:0]  e_dev;
	logic [BLK_W-1:0]  e_blk;
	logic [BKT_W-1:0]  e_bkt;
	logic [REF_W-1:0]  e_ref;
	logic [TICK_W-1:0] e_time;
	logic              e_cv;
	logic              e_free;

	logic [SLOT_W-1:0]  r_slot;
	logic               r_hit;
	logic               r_rd;
	logic [FAULT_W-1:0] r_fault;
	logic               w_en;
	logic               w_tag;
	logic               w_time;
	logic [REF_W-1:0]   w_ref;
	logic               w_cv;

	// residue modulo NUM_BUCKETS: weighted byte sum, reciprocal quotient, remainder
	always_comb begin
		sum_n = RES_W'(blk_q[7:0])   * RES_W'(BYTE_WT0)
			+ RES_W'(blk_q[15:8])  * RES_W'(BYTE_WT1)
			+ RES_W'(blk_q[23:16]) * RES_W'(BYTE_WT2)
			+ RES_W'(blk_q[31:24]) * RES_W'(BYTE_WT3);
		prod     = MUL_W'(sum_q) * MUL_W'(RECIP_M);
		rem_full = sum_q - quo_q * RES_W'(NUM_BUCKETS);
		rem_n    = rem_full[BKT_W-1:0];
	end

	assign idx_ok = (32'(idx_q) < NUM_ENTRIES);

	always_comb begin
		if (op_q == OP_GET) begin
			if (hit_found_q)     tgt_idx = hit_idx_q;
			else if (bf_found_q) tgt_idx = bf_idx_q;
			else                 tgt_idx = gf_idx_q;
		end else begin
			tgt_idx = idx_ok ? ENT_W'(idx_q) : '0;
		end
	end

	assign rd_addr = cmd.scan_step ? scan_q : tgt_idx;
	assign e_dev   = tag_dev_q[rd_addr];
	assign e_blk   = tag_blk_q[rd_addr];
	assign e_bkt   = tag_bkt_q[rd_addr];
	assign e_ref   = ref_q[rd_addr];
	assign e_time  = rtime_q[rd_addr];
	assign e_cv    = cv_q[rd_addr];
	assign e_free  = (e_ref == '0);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(operation);
			dev_q <= device;
			blk_q <= block_number;
			idx_q <= entry_index;
			now_q <= now_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q       <= '0;
			sum_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			scan_q      <= '0;
			hit_found_q <= 1'b0;
			hit_idx_q   <= '0;
			bf_found_q  <= 1'b0;
			bf_idx_q    <= '0;
			bf_time_q   <= '0;
			gf_found_q  <= 1'b0;
			gf_idx_q    <= '0;
			gf_time_q   <= '0;
		end else if (cmd.capture) begin
			dig_q       <= '0;
			rem_q       <= '0;
			scan_q      <= '0;
			hit_found_q <= 1'b0;
			bf_found_q  <= 1'b0;
			gf_found_q  <= 1'b0;
		end else if (cmd.dig_step) begin
			dig_q <= dig_q + 1'b1;
			sum_q <= sum_n;
			quo_q <= prod[RECIP_SH +: RES_W];
			rem_q <= rem_n;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (!hit_found_q && e_dev == dev_q && e_blk == blk_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= scan_q;
			end
			if (e_free && e_bkt == rem_q && (!bf_found_q || e_time < bf_time_q)) begin
				bf_found_q <= 1'b1;
				bf_idx_q   <= scan_q;
				bf_time_q  <= e_time;
			end
			if (e_free && (!gf_found_q || e_time < gf_time_q)) begin
				gf_found_q <= 1'b1;
				gf_idx_q   <= scan_q;
				gf_time_q  <= e_time;
			end
		end
	end

	always_comb begin
		r_slot  = (op_q == OP_GET) ? SLOT_W'(tgt_idx) : SLOT_W'(idx_q);
		r_hit   = 1'b0;
		r_rd    = 1'b0;
		r_fault = FAULT_OK;
		w_en    = 1'b0;
		w_tag   = 1'b0;
		w_time  = 1'b0;
		w_ref   = e_ref;
		w_cv    = e_cv;
		if (op_q == OP_GET) begin
			if (hit_found_q) begin
				r_hit = 1'b1;
				if (e_ref == REF_MAX) begin
					r_fault = FAULT_REFCNT;
				end else begin
					w_en  = 1'b1;
					w_ref = e_ref + 1'b1;
					w_cv  = 1'b1;
					r_rd  = !e_cv;
				end
			end else if (bf_found_q || gf_found_q) begin
				w_en  = 1'b1;
				w_tag = 1'b1;
				w_ref = REF_W'(1);
				w_cv  = 1'b1;
				r_rd  = 1'b1;
			end else begin
				r_fault = FAULT_NOFREE;
				r_slot  = '0;
			end
		end else if (!idx_ok) begin
			r_fault = FAULT_REFCNT;
		end else if (op_q == OP_PIN) begin
			if (e_ref == REF_MAX) begin
				r_fault = FAULT_REFCNT;
			end else begin
				w_en  = 1'b1;
				w_ref = e_ref + 1'b1;
			end
		end else begin
			if (e_free) begin
				r_fault = FAULT_REFCNT;
			end else begin
				w_en   = 1'b1;
				w_ref  = e_ref - 1'b1;
				w_time = (op_q == OP_RELEASE) && (e_ref == REF_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				tag_dev_q[i] <= '0;
				tag_blk_q[i] <= BLK_W'(init_bucket(i));
				tag_bkt_q[i] <= init_bucket(i);
				ref_q[i]     <= '0;
				rtime_q[i]   <= '0;
			end
			cv_q <= '0;
		end else if (cmd.exec && w_en) begin
			ref_q[tgt_idx] <= w_ref;
			cv_q[tgt_idx]  <= w_cv;
			if (w_tag) begin
				tag_dev_q[tgt_idx] <= dev_q;
				tag_blk_q[tgt_idx] <= blk_q;
				tag_bkt_q[tgt_idx] <= rem_q;
			end
			if (w_time) rtime_q[tgt_idx] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			slot_q  <= r_slot;
			hit_q   <= r_hit;
			rd_q    <= r_rd;
			fault_q <= r_fault;
		end
	end

	assign status.dig_last  = (dig_q == DIG_CNT_W'(DIG_STEPS - 1));
	assign status.scan_last = (scan_q == ENT_W'(NUM_ENTRIES - 1));
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign was_hit    = hit_q;
	assign needs_read = rd_q;
	assign fault      = fault_q;

endmodule
